// File: hw/rtl/mte_pkg.sv
// Shared types and constants of the MIDI track event encoder.
`default_nettype none
package mte_pkg;

	localparam int META_CHUNK_MAX = 127;
	localparam int JOB_BYTES      = 9;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [2:0] CMD_START   = 3'd0;
	localparam logic [2:0] CMD_SHORT   = 3'd1;
	localparam logic [2:0] CMD_SYSEX   = 3'd2;
	localparam logic [2:0] CMD_META    = 3'd3;
	localparam logic [2:0] CMD_PAYLOAD = 3'd4;
	localparam logic [2:0] CMD_END     = 3'd5;

	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [3:0]                count;
	} job_t;

endpackage
`default_nettype wire

// File: hw/rtl/mte_in_if.sv
// Event request channel of the MIDI track event encoder.
`default_nettype none
interface mte_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [27:0] delta_time;
	logic [7:0]  status;
	logic [7:0]  data1;
	logic [7:0]  data2;
	logic [27:0] length;
	logic [7:0]  payload_byte;

	modport source (output valid, cmd, delta_time, status, data1, data2, length, payload_byte,
		input ready);
	modport sink (input valid, cmd, delta_time, status, data1, data2, length, payload_byte,
		output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mte_out_if.sv
// Byte request channel of the MIDI track event encoder.
`default_nettype none
interface mte_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mte_front.sv
// Front end: accepts events, tracks encoder state and builds byte jobs.
`default_nettype none
module mte_front #(
	parameter int CHUNK_MAX = mte_pkg::META_CHUNK_MAX
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata,
	mte_in_if.sink             evt,
	input  wire logic          q_full,
	output logic               q_push,
	output mte_pkg::job_t      q_din
);
	import mte_pkg::*;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
	} vlq_t;

	function automatic vlq_t vlq_enc(input logic [27:0] v);
		vlq_t r;
		logic [2:0] g;
		if (v[27:21] != 7'd0)      g = 3'd4;
		else if (v[20:14] != 7'd0) g = 3'd3;
		else if (v[13:7] != 7'd0)  g = 3'd2;
		else                       g = 3'd1;
		r.count = g;
		r.bytes = '0;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < g) begin
				r.bytes[2'(g - 3'd1 - 3'(i))] = {(i != 0), v[7*i +: 7]};
			end
		end
		return r;
	endfunction

	function automatic logic [1:0] data_count(input logic [7:0] s);
		logic [1:0] k;
		if (s < 8'h80) k = 2'd2;
		else if (s[7:4] == 4'hC || s[7:4] == 4'hD) k = 2'd1;
		else if (s[7:4] == 4'hF) begin
			if (s == 8'hF1 || s == 8'hF3) k = 2'd1;
			else if (s == 8'hF2)          k = 2'd2;
			else                          k = 2'd0;
		end else k = 2'd2;
		return k;
	endfunction

	function automatic logic [6:0] chunk_size(input logic [27:0] left);
		return (left > 28'(CHUNK_MAX)) ? 7'(CHUNK_MAX) : left[6:0];
	endfunction

	logic        disable_rs_q;
	logic [7:0]  running_status_q, running_status_d;
	logic        end_written_q, end_written_d;
	logic [7:0]  meta_kind_q, meta_kind_d;
	logic [27:0] payload_left_q, payload_left_d;
	logic [6:0]  chunk_left_q, chunk_left_d;
	logic        is_meta_q, is_meta_d;

	logic [JOB_BYTES-1:0][7:0] b;
	logic [3:0]  nb;
	logic [6:0]  cl_v;
	logic [27:0] pl_v;
	vlq_t        vd, vl;
	logic [1:0]  k;
	logic        accept;

	assign evt.ready = !q_full;
	assign accept    = evt.valid && evt.ready;

	always_comb begin
		b  = '0;
		nb = 4'd0;
		running_status_d = running_status_q;
		end_written_d    = end_written_q;
		meta_kind_d      = meta_kind_q;
		payload_left_d   = payload_left_q;
		chunk_left_d     = chunk_left_q;
		is_meta_d        = is_meta_q;
		vd   = vlq_enc(evt.delta_time);
		vl   = vlq_enc(evt.length);
		k    = data_count(evt.status);
		cl_v = chunk_left_q;
		pl_v = payload_left_q;
		case (evt.cmd)
			CMD_START: begin
				running_status_d = 8'h00;
				end_written_d    = 1'b0;
				meta_kind_d      = 8'h00;
				payload_left_d   = '0;
				chunk_left_d     = '0;
				is_meta_d        = 1'b0;
			end
			CMD_SHORT: begin
				payload_left_d = '0;
				chunk_left_d   = '0;
				is_meta_d      = 1'b0;
				for (int j = 0; j < 4; j++) begin
					if (3'(j) < vd.count) begin
						b[nb] = vd.bytes[j];
						nb = nb + 4'd1;
					end
				end
				if (disable_rs_q || evt.status != running_status_q) begin
					b[nb] = evt.status;
					nb = nb + 4'd1;
				end
				if (k >= 2'd1) begin
					b[nb] = evt.data1;
					nb = nb + 4'd1;
				end
				if (k >= 2'd2) begin
					b[nb] = evt.data2;
					nb = nb + 4'd1;
				end
				running_status_d = evt.status;
			end
			CMD_SYSEX: begin
				chunk_left_d = '0;
				is_meta_d    = 1'b0;
				for (int j = 0; j < 4; j++) begin
					if (3'(j) < vd.count) begin
						b[nb] = vd.bytes[j];
						nb = nb + 4'd1;
					end
				end
				b[nb] = evt.status;
				nb = nb + 4'd1;
				for (int j = 0; j < 4; j++) begin
					if (3'(j) < vl.count) begin
						b[nb] = vl.bytes[j];
						nb = nb + 4'd1;
					end
				end
				payload_left_d   = evt.length;
				running_status_d = evt.status;
			end
			CMD_META: begin
				for (int j = 0; j < 4; j++) begin
					if (3'(j) < vd.count) begin
						b[nb] = vd.bytes[j];
						nb = nb + 4'd1;
					end
				end
				b[nb] = 8'hFF;
				nb = nb + 4'd1;
				b[nb] = evt.data1;
				nb = nb + 4'd1;
				chunk_left_d = chunk_size(evt.length);
				b[nb] = {1'b0, chunk_left_d};
				nb = nb + 4'd1;
				payload_left_d = evt.length;
				is_meta_d      = 1'b1;
				meta_kind_d    = evt.data1;
				if (evt.data1 == 8'h2F) end_written_d = 1'b1;
				running_status_d = 8'hFF;
			end
			CMD_PAYLOAD: begin
				if (payload_left_q != 28'd0) begin
					if (is_meta_q && chunk_left_q == 7'd0) begin
						b[0] = 8'h00;
						b[1] = 8'hFF;
						b[2] = meta_kind_q;
						cl_v = chunk_size(payload_left_q);
						b[3] = {1'b0, cl_v};
						nb = 4'd4;
					end
					b[nb] = evt.payload_byte;
					nb = nb + 4'd1;
					pl_v = payload_left_q - 28'd1;
					payload_left_d = pl_v;
					chunk_left_d = (cl_v != 7'd0) ? cl_v - 7'd1 : cl_v;
					if (pl_v == 28'd0) begin
						chunk_left_d = '0;
						is_meta_d    = 1'b0;
					end
				end
			end
			CMD_END: begin
				payload_left_d = '0;
				chunk_left_d   = '0;
				is_meta_d      = 1'b0;
				if (!end_written_q) begin
					b[0] = 8'h00;
					b[1] = 8'hFF;
					b[2] = 8'h2F;
					b[3] = 8'h00;
					nb = 4'd4;
					end_written_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign q_push      = accept && (nb != 4'd0);
	assign q_din.bytes = b;
	assign q_din.count = nb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disable_rs_q     <= 1'b0;
			running_status_q <= '0;
			end_written_q    <= 1'b0;
			meta_kind_q      <= '0;
			payload_left_q   <= '0;
			chunk_left_q     <= '0;
			is_meta_q        <= 1'b0;
		end else begin
			if (cfg_we) disable_rs_q <= cfg_wdata;
			if (accept) begin
				running_status_q <= running_status_d;
				end_written_q    <= end_written_d;
				meta_kind_q      <= meta_kind_d;
				payload_left_q   <= payload_left_d;
				chunk_left_q     <= chunk_left_d;
				is_meta_q        <= is_meta_d;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mte_queue.sv
// Short job queue between the front end and the byte serializer.
`default_nettype none
module mte_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  mte_pkg::job_t din,
	input  wire logic     pop,
	output mte_pkg::job_t head,
	output logic          empty,
	output logic          full
);
	import mte_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t            slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mte_back.sv
// Back end: sends the bytes of each queued job, one per cycle while the receiver is ready.
`default_nettype none
module mte_back (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  mte_pkg::job_t head,
	input  wire logic     empty,
	output logic          pop,
	mte_out_if.source     obyte
);
	import mte_pkg::*;

	logic [3:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       load;
	logic       at_end;

	assign load   = !empty && (!valid_q || obyte.ready);
	assign at_end = (idx_q == head.count - 4'd1);
	assign pop    = load && at_end;

	assign obyte.valid    = valid_q;
	assign obyte.out_byte = byte_q;
	assign obyte.last     = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.bytes[idx_q];
			last_q <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 4'd0 : idx_q + 4'd1;
			end else if (obyte.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/midi_track_event_encoder.sv
// Top level of the MIDI track event encoder.
// Turns track events into standard MIDI file track bytes.
// evt: event requests (cmd, delta_time, status, data1, data2, length,
//   payload_byte), taken when valid and ready are high at a clock edge.
// obyte: one encoded byte per request, last marks the final byte of each queued job.
// cfg_we/cfg_wdata: writes disable_running_status; write only while idle.
// The front end takes one event per cycle while the job queue has room;
// events that make no bytes only update state. The serializer sends one
// byte per cycle while the receiver is ready; a job has 1 byte for a
// payload byte (5 when it opens a new meta chunk), up to 9 for an event header.
// An event's bytes are registered in the job queue, then in the output register.
// A stalled receiver holds the output register; the queue (4 jobs) then
// fills and evt.ready drops.
// Reset clears running status, end-of-track flag, payload state, queue
// and output valid flag; disable_running_status resets to 0.
`default_nettype none
module midi_track_event_encoder #(
	parameter int META_CHUNK_MAX = mte_pkg::META_CHUNK_MAX
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	mte_in_if.sink    evt,
	mte_out_if.source obyte
);
	import mte_pkg::*;

	job_t q_din, q_head;
	logic q_push, q_pop, q_empty, q_full;

	mte_front #(.CHUNK_MAX(META_CHUNK_MAX)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.evt(evt), .q_full(q_full), .q_push(q_push), .q_din(q_din)
	);

	mte_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(q_din),
		.pop(q_pop), .head(q_head), .empty(q_empty), .full(q_full)
	);

	mte_back u_back (
		.clk(clk), .arst_n(arst_n), .head(q_head), .empty(q_empty),
		.pop(q_pop), .obyte(obyte)
	);

endmodule
`default_nettype wire
